// File: rtl/bie_pkg.sv
// Package for the beacon information element parser.
// Element ids, event kinds, queue sizing and the event record types.
// No dependencies; imported by every module of the block.
package bie_pkg;

    // Element ids
    localparam logic [7:0] ID_SSID    = 8'd0;
    localparam logic [7:0] ID_CHANNEL = 8'd3;
    localparam logic [7:0] ID_RSN     = 8'd48;

    // RSN layout: pairwise count sits at data offset 6, suites are 4 bytes
    localparam logic [7:0] RSN_COUNT_OFFSET = 8'd6;
    localparam int unsigned RSN_POS_W       = 20;

    // Suite type bytes and auth classes
    localparam logic [7:0] SUITE_CCMP = 8'd4;
    localparam logic [7:0] SUITE_TKIP = 8'd2;
    localparam logic [1:0] AUTH_PSK   = 2'd2;
    localparam logic [1:0] AUTH_OTHER = 2'd3;

    // Verdict codes
    localparam logic [7:0] VERDICT_NONE = 8'd0;
    localparam logic [7:0] VERDICT_WPA  = 8'd1;
    localparam logic [7:0] VERDICT_WPA2 = 8'd2;

    // Event kinds
    localparam logic [2:0] KIND_CHANNEL  = 3'd0;
    localparam logic [2:0] KIND_SSID     = 3'd1;
    localparam logic [2:0] KIND_SSID_END = 3'd2;
    localparam logic [2:0] KIND_CIPHER   = 3'd3;
    localparam logic [2:0] KIND_AKM      = 3'd4;
    localparam logic [2:0] KIND_VERDICT  = 3'd5;

    // Event queue between front and back
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int unsigned QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] value;
        logic       last;
    } t_event;

    // Up to two events produced by one input byte
    typedef struct packed {
        logic [1:0] count;
        t_event     ev0;
        t_event     ev1;
    } t_push;

endpackage

// File: rtl/bie_front.sv
// Front end of the element parser: accepts body bytes, walks the element
// id/length/data and produces up to two events per byte.
// Depends on bie_pkg.
module bie_front
    import bie_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_byte,
    input  logic        i_eof,
    input  logic        i_space_ok,
    output t_push       o_push
);

    localparam logic [1:0] PH_ID   = 2'd0;
    localparam logic [1:0] PH_LEN  = 2'd1;
    localparam logic [1:0] PH_DATA = 2'd2;

    logic [1:0]  r_phase,   n_phase;
    logic [7:0]  r_id,      n_id;
    logic [7:0]  r_rem,     n_rem;
    logic [7:0]  r_length,  n_length;
    logic [7:0]  r_pos,     n_pos;
    logic [15:0] r_pw_cnt,  n_pw_cnt;
    logic [15:0] r_akm_cnt, n_akm_cnt;
    logic        r_ccmp,    n_ccmp;
    logic        r_tkip,    n_tkip;
    logic [1:0]  r_auth,    n_auth;
    logic [7:0]  r_low,     n_low;

    logic                 accept;
    logic                 data_vld;
    logic [2:0]           data_kind;
    logic [7:0]           data_val;
    logic                 fin;
    logic                 fin_vld;
    logic [2:0]           fin_kind;
    logic [7:0]           fin_val;
    logic [RSN_POS_W-1:0] pos_w;
    logic [RSN_POS_W-1:0] pw_start;
    logic [RSN_POS_W-1:0] pw_end;
    logic [RSN_POS_W-1:0] akm_start;
    logic [RSN_POS_W-1:0] akm_end;

    assign accept  = i_valid & i_space_ok;
    assign o_ready = i_space_ok;

    // RSN section bounds, suites are 4 bytes so counts scale by a shift
    assign pos_w     = RSN_POS_W'(r_pos);
    assign pw_start  = RSN_POS_W'(RSN_COUNT_OFFSET) + RSN_POS_W'(2);
    assign pw_end    = pw_start + RSN_POS_W'({r_pw_cnt, 2'b00});
    assign akm_start = pw_end + RSN_POS_W'(2);
    assign akm_end   = akm_start + RSN_POS_W'({r_akm_cnt, 2'b00});

    // Next state and the data event of this byte
    always_comb begin
        n_phase   = r_phase;
        n_id      = r_id;
        n_rem     = r_rem;
        n_length  = r_length;
        n_pos     = r_pos;
        n_pw_cnt  = r_pw_cnt;
        n_akm_cnt = r_akm_cnt;
        n_ccmp    = r_ccmp;
        n_tkip    = r_tkip;
        n_auth    = r_auth;
        n_low     = r_low;
        data_vld  = 1'b0;
        data_kind = KIND_CHANNEL;
        data_val  = i_byte;
        fin       = 1'b0;
        case (r_phase)
            PH_LEN: begin
                n_length  = i_byte;
                n_rem     = i_byte;
                n_pos     = '0;
                n_pw_cnt  = '0;
                n_akm_cnt = '0;
                n_ccmp    = 1'b0;
                n_tkip    = 1'b0;
                n_auth    = '0;
                n_low     = '0;
                if (i_byte == 8'd0) begin
                    fin     = 1'b1;
                    n_phase = PH_ID;
                end else begin
                    n_phase = PH_DATA;
                end
            end
            PH_DATA: begin
                n_rem = r_rem - 8'd1;
                if (r_id == ID_CHANNEL && r_length == 8'd1) begin
                    data_vld  = 1'b1;
                    data_kind = KIND_CHANNEL;
                end else if (r_id == ID_SSID) begin
                    data_vld  = 1'b1;
                    data_kind = KIND_SSID;
                end else if (r_id == ID_RSN) begin
                    if (r_pos == RSN_COUNT_OFFSET) begin
                        n_low = i_byte;
                    end else if (r_pos == RSN_COUNT_OFFSET + 8'd1) begin
                        n_pw_cnt = {i_byte, r_low};
                    end else if (pos_w >= pw_start && pos_w < pw_end) begin
                        // suite type is the fourth byte; pw_start is 0 mod 4
                        if (r_pos[1:0] == 2'd3) begin
                            if (i_byte == SUITE_CCMP) n_ccmp = 1'b1;
                            if (i_byte == SUITE_TKIP) n_tkip = 1'b1;
                            data_vld  = 1'b1;
                            data_kind = KIND_CIPHER;
                        end
                    end else if (pos_w == pw_end) begin
                        n_low = i_byte;
                    end else if (pos_w == pw_end + RSN_POS_W'(1)) begin
                        n_akm_cnt = {i_byte, r_low};
                    end else if (pos_w >= akm_start && pos_w < akm_end) begin
                        // akm_start is 2 mod 4, so the fourth byte is 1 mod 4
                        if (r_pos[1:0] == 2'd1) begin
                            n_auth    = (i_byte <= 8'd2) ? i_byte[1:0] : AUTH_OTHER;
                            data_vld  = 1'b1;
                            data_kind = KIND_AKM;
                            data_val  = {6'd0, n_auth};
                        end
                    end
                end
                n_pos = r_pos + 8'd1;
                if (n_rem == 8'd0) begin
                    fin     = 1'b1;
                    n_phase = PH_ID;
                end
            end
            default: begin
                n_id    = i_byte;
                n_phase = PH_LEN;
            end
        endcase
        if (i_eof) begin
            n_phase = PH_ID;
        end
    end

    // Element end event: SSID length or RSN verdict
    always_comb begin
        fin_vld  = 1'b0;
        fin_kind = KIND_SSID_END;
        fin_val  = n_length;
        if (fin && n_id == ID_SSID) begin
            fin_vld = 1'b1;
        end else if (fin && n_id == ID_RSN) begin
            fin_vld  = 1'b1;
            fin_kind = KIND_VERDICT;
            if (n_auth == AUTH_PSK && n_ccmp) begin
                fin_val = VERDICT_WPA2;
            end else if (n_auth == AUTH_PSK && n_tkip) begin
                fin_val = VERDICT_WPA;
            end else begin
                fin_val = VERDICT_NONE;
            end
        end
    end

    // Pack the events in order, the last one carries the run marker
    always_comb begin
        o_push = '0;
        if (accept) begin
            if (data_vld) begin
                o_push.ev0 = '{kind: data_kind, value: data_val, last: !fin_vld};
                o_push.ev1 = '{kind: fin_kind, value: fin_val, last: 1'b1};
                o_push.count = fin_vld ? 2'd2 : 2'd1;
            end else if (fin_vld) begin
                o_push.ev0   = '{kind: fin_kind, value: fin_val, last: 1'b1};
                o_push.count = 2'd1;
            end
        end
    end

    // Parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_ID;
            r_id      <= '0;
            r_rem     <= '0;
            r_length  <= '0;
            r_pos     <= '0;
            r_pw_cnt  <= '0;
            r_akm_cnt <= '0;
            r_ccmp    <= 1'b0;
            r_tkip    <= 1'b0;
            r_auth    <= '0;
            r_low     <= '0;
        end else if (accept) begin
            r_phase   <= n_phase;
            r_id      <= n_id;
            r_rem     <= n_rem;
            r_length  <= n_length;
            r_pos     <= n_pos;
            r_pw_cnt  <= n_pw_cnt;
            r_akm_cnt <= n_akm_cnt;
            r_ccmp    <= n_ccmp;
            r_tkip    <= n_tkip;
            r_auth    <= n_auth;
            r_low     <= n_low;
        end
    end

endmodule

// File: rtl/bie_queue.sv
// Short event queue between parser front end and output stage.
// Takes up to two events per cycle, gives one. Depends on bie_pkg.
module bie_queue
    import bie_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_push  i_push,
    input  logic   i_pop,
    output t_event o_head,
    output logic   o_empty,
    output logic   o_space_ok
);

    t_event              r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr, n_wr;
    logic [QUEUE_AW-1:0] r_rd, n_rd;
    logic [QUEUE_CW-1:0] r_cnt, n_cnt;
    logic [QUEUE_AW-1:0] wr_next;

    assign wr_next    = r_wr + QUEUE_AW'(1);
    assign o_head     = r_mem[r_rd];
    assign o_empty    = (r_cnt == '0);
    assign o_space_ok = (r_cnt <= QUEUE_CW'(QUEUE_DEPTH - 2));

    // Pointer and fill count update
    always_comb begin
        n_wr  = r_wr + QUEUE_AW'(i_push.count);
        n_rd  = i_pop ? r_rd + QUEUE_AW'(1) : r_rd;
        n_cnt = r_cnt + QUEUE_CW'(i_push.count) - QUEUE_CW'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // Entry writes, second event lands one slot after the first
    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr] <= i_push.ev0;
        end
        if (i_push.count == 2'd2) begin
            r_mem[wr_next] <= i_push.ev1;
        end
    end

endmodule

// File: rtl/bie_back.sv
// Output stage of the element parser: pulls events from the queue into
// a registered master stream port. Depends on bie_pkg.
module bie_back
    import bie_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_event     i_head,
    input  logic       i_empty,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_data,
    output logic [2:0] o_user,
    output logic       o_last
);

    logic   r_valid, n_valid;
    t_event r_ev;

    // Refill when the register is empty or its event is being taken
    assign o_pop   = !i_empty && (!r_valid || i_ready);
    assign n_valid = o_pop || (r_valid && !i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_ev <= i_head;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_ev.value;
    assign o_user  = r_ev.kind;
    assign o_last  = r_ev.last;

endmodule

// File: rtl/beacon_info_element_parser.sv
// Beacon information element parser, top level.
// First event of a byte goes into the event queue, then the m_axis output register.
// Throughput: one body byte per cycle unless stalled; one event out per cycle, so a
// byte that ends an SSID or RSN element with a data event occupies two output slots.
// Input stalls only when the 4-entry event queue has fewer than two free slots.
// Reset (i_rst_n low, synchronous) clears parser state, queue and output valid.
module beacon_info_element_parser
    import bie_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] body_byte
    input  logic       s_axis_tlast,   // end_of_frame
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] event_value
    output logic [2:0] m_axis_tuser,   // [2:0] event_kind
    output logic       m_axis_tlast    // last_of_run
);

    t_push  push;
    t_event head;
    logic   empty;
    logic   space_ok;
    logic   pop;

    bie_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_byte     (s_axis_tdata),
        .i_eof      (s_axis_tlast),
        .i_space_ok (space_ok),
        .o_push     (push)
    );

    bie_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_pop      (pop),
        .o_head     (head),
        .o_empty    (empty),
        .o_space_ok (space_ok)
    );

    bie_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .i_empty (empty),
        .o_pop   (pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (m_axis_tdata),
        .o_user  (m_axis_tuser),
        .o_last  (m_axis_tlast)
    );

endmodule

// File: rtl/bie_checker.sv
// Port-level checker for the beacon information element parser.
// Depends on bie_pkg; bound to beacon_info_element_parser below.
module bie_checker
    import bie_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic [2:0] m_axis_tuser,
    input logic       m_axis_tlast
);

    // Stalled output transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("output changed while stalled");

    // Element end events are always the last of their run
    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == KIND_SSID_END || m_axis_tuser == KIND_VERDICT)
            |-> m_axis_tlast)
        else $error("element end event without last marker");

    // Verdict code range
    a_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == KIND_VERDICT |-> m_axis_tdata <= VERDICT_WPA2)
        else $error("bad verdict code");

    // Auth class fits two bits
    a_akm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == KIND_AKM |-> m_axis_tdata[7:2] == 6'd0)
        else $error("bad auth class");

endmodule

bind beacon_info_element_parser bie_checker u_bie_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

// File: tb/sv/tb_beacon_info_element_parser.sv
// Self-checking testbench for beacon_info_element_parser.
// Streams 802.11 tagged-element bytes and checks every event against a predictor class.
// Depends on bie_pkg and the beacon_info_element_parser RTL.
module tb_beacon_info_element_parser
    import bie_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CLK_PERIOD   = 12;
    localparam int unsigned RESET_CYCLES = 6;
    localparam int unsigned RANDOM_BYTES = 800;
    localparam int unsigned DRAIN_CYCLES = 20;
    localparam int unsigned CYCLE_LIMIT  = 600000;
    localparam int unsigned SUITE_BYTES  = 4;
    localparam logic [7:0]  AUTH_8021X   = 8'd1;

    typedef enum logic [1:0] {
        PH_ID   = 2'd0,
        PH_LEN  = 2'd1,
        PH_DATA = 2'd2
    } t_phase;

    typedef struct {
        logic [7:0] body;
        bit         eof;
    } t_body_item;

    // Predicts the event stream of the element walker and checks it
    class element_event_scoreboard;
        t_phase      phase;
        logic [7:0]  elem_id;
        logic [7:0]  elem_left;
        logic [7:0]  elem_len;
        logic [7:0]  rsn_pos;
        logic [15:0] pw_count;
        logic [15:0] akm_count;
        logic [7:0]  count_lo;
        bit          saw_ccmp;
        bit          saw_tkip;
        logic [1:0]  last_auth;
        t_event      step_events[$];
        t_event      expected_events[$];
        int unsigned errors;
        int unsigned n_checked;
        int unsigned n_verdicts;
        int unsigned n_ssid_ends;

        function new();
            phase       = PH_ID;
            elem_id     = '0;
            elem_left   = '0;
            elem_len    = '0;
            rsn_pos     = '0;
            pw_count    = '0;
            akm_count   = '0;
            count_lo    = '0;
            saw_ccmp    = 1'b0;
            saw_tkip    = 1'b0;
            last_auth   = '0;
            errors      = 0;
            n_checked   = 0;
            n_verdicts  = 0;
            n_ssid_ends = 0;
        endfunction

        function int unsigned pending();
            return expected_events.size();
        endfunction

        function void add_event(logic [2:0] kind, logic [7:0] value);
            t_event ev;
            ev.kind  = kind;
            ev.value = value;
            ev.last  = 1'b0;
            step_events.push_back(ev);
        endfunction

        // SSID end or RSN verdict when an element completes
        function void close_element();
            logic [7:0] verdict;
            verdict = VERDICT_NONE;
            if (elem_id == ID_SSID) begin
                add_event(KIND_SSID_END, elem_len);
            end else if (elem_id == ID_RSN) begin
                if (last_auth == AUTH_PSK) begin
                    if (saw_ccmp) verdict = VERDICT_WPA2;
                    else if (saw_tkip) verdict = VERDICT_WPA;
                end
                add_event(KIND_VERDICT, verdict);
            end
        endfunction

        // RSN body: counts, pairwise suites, AKM suites
        function void rsn_data(logic [7:0] b);
            int unsigned p, pw_start, pw_end, akm_start, akm_end;
            p         = rsn_pos;
            pw_start  = RSN_COUNT_OFFSET + 2;
            pw_end    = pw_start + SUITE_BYTES * pw_count;
            akm_start = pw_end + 2;
            akm_end   = akm_start + SUITE_BYTES * akm_count;
            if (p == RSN_COUNT_OFFSET) begin
                count_lo = b;
            end else if (p == RSN_COUNT_OFFSET + 1) begin
                pw_count = {b, count_lo};
            end else if (p >= pw_start && p < pw_end) begin
                if ((p - pw_start) % SUITE_BYTES == SUITE_BYTES - 1) begin
                    if (b == SUITE_CCMP) saw_ccmp = 1'b1;
                    if (b == SUITE_TKIP) saw_tkip = 1'b1;
                    add_event(KIND_CIPHER, b);
                end
            end else if (p == pw_end) begin
                count_lo = b;
            end else if (p == pw_end + 1) begin
                akm_count = {b, count_lo};
            end else if (p >= akm_start && p < akm_end) begin
                if ((p - akm_start) % SUITE_BYTES == SUITE_BYTES - 1) begin
                    last_auth = (b <= 8'd2) ? b[1:0] : AUTH_OTHER;
                    add_event(KIND_AKM, {6'd0, last_auth});
                end
            end
        endfunction

        // One accepted input transaction
        function void note_body_byte(logic [7:0] b, bit eof);
            step_events.delete();
            case (phase)
                PH_LEN: begin
                    elem_len  = b;
                    elem_left = b;
                    rsn_pos   = '0;
                    pw_count  = '0;
                    akm_count = '0;
                    count_lo  = '0;
                    saw_ccmp  = 1'b0;
                    saw_tkip  = 1'b0;
                    last_auth = '0;
                    if (b == 8'd0) begin
                        close_element();
                        phase = PH_ID;
                    end else begin
                        phase = PH_DATA;
                    end
                end
                PH_DATA: begin
                    elem_left = elem_left - 8'd1;
                    if (elem_id == ID_CHANNEL && elem_len == 8'd1) add_event(KIND_CHANNEL, b);
                    else if (elem_id == ID_SSID) add_event(KIND_SSID, b);
                    else if (elem_id == ID_RSN) rsn_data(b);
                    rsn_pos = rsn_pos + 8'd1;
                    if (elem_left == 8'd0) begin
                        close_element();
                        phase = PH_ID;
                    end
                end
                default: begin
                    elem_id = b;
                    phase   = PH_LEN;
                end
            endcase
            if (eof) phase = PH_ID;
            if (step_events.size() > 0) step_events[step_events.size() - 1].last = 1'b1;
            foreach (step_events[i]) expected_events.push_back(step_events[i]);
        endfunction

        // One accepted output transaction
        function void check_event(logic [2:0] kind, logic [7:0] value, logic is_last);
            t_event exp_ev;
            if (expected_events.size() == 0) begin
                $error("unexpected event: kind %0d value %0d last %0d", kind, value, is_last);
                errors++;
                return;
            end
            exp_ev = expected_events.pop_front();
            n_checked++;
            if (exp_ev.kind == KIND_VERDICT) n_verdicts++;
            if (exp_ev.kind == KIND_SSID_END) n_ssid_ends++;
            if (kind !== exp_ev.kind) begin
                $error("event_kind: expected %0d, got %0d", exp_ev.kind, kind);
                errors++;
            end
            if (value !== exp_ev.value) begin
                $error("event_value: expected %0d, got %0d", exp_ev.value, value);
                errors++;
            end
            if (is_last !== exp_ev.last) begin
                $error("last_of_run: expected %0d, got %0d", exp_ev.last, is_last);
                errors++;
            end
        endfunction
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = '0;    // [7:0] body_byte
    logic       s_axis_tlast = 1'b0;  // end_of_frame
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;         // [7:0] event_value
    logic [2:0] m_axis_tuser;         // [2:0] event_kind
    logic       m_axis_tlast;         // last_of_run

    element_event_scoreboard sb;
    t_body_item  stim_q[$];
    logic [7:0]  frame_q[$];
    int unsigned n_frames;
    int unsigned n_cut_frames;
    int unsigned cycle_count = 0;
    int unsigned ready_hold = 0;
    int unsigned stall_len;
    bit          quiet = 1'b0;

    beacon_info_element_parser dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Gap length: mostly none or short, a few long; none at all in quiet stretches
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (quiet) return 0;
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic void frame_byte(logic [7:0] b);
        frame_q.push_back(b);
    endfunction

    // Move the frame into the stimulus list; keep == 0 keeps it whole
    function automatic void close_frame(int unsigned keep);
        if (keep == 0 || keep > frame_q.size()) keep = frame_q.size();
        if (keep < frame_q.size()) n_cut_frames++;
        for (int unsigned i = 0; i < keep; i++) begin
            stim_q.push_back('{body: frame_q[i], eof: (i == keep - 1)});
        end
        if (keep != 0) n_frames++;
        frame_q.delete();
    endfunction

    function automatic logic [7:0] pick_cipher();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 40) return SUITE_CCMP;
        if (r < 70) return SUITE_TKIP;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] pick_akm();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 45) return {6'd0, AUTH_PSK};
        if (r < 70) return AUTH_8021X;
        return 8'($urandom_range(0, 255));
    endfunction

    // Well-formed RSN element, sometimes with bogus counts or a short length
    function automatic void put_rsn_element();
        logic [7:0]  data_q[$];
        logic [15:0] pw_field, akm_field;
        int unsigned n_pw, n_akm, len;
        n_pw      = $urandom_range(0, 3);
        n_akm     = $urandom_range(0, 3);
        pw_field  = 16'(n_pw);
        akm_field = 16'(n_akm);
        if ($urandom_range(0, 15) == 0) pw_field = 16'($urandom_range(0, 65535));
        if ($urandom_range(0, 15) == 0) akm_field = 16'($urandom_range(0, 65535));
        data_q = '{8'h01, 8'h00, 8'h00, 8'h0F, 8'hAC, pick_cipher(),
                   pw_field[7:0], pw_field[15:8]};
        repeat (n_pw) begin
            data_q.push_back(8'h00);
            data_q.push_back(8'h0F);
            data_q.push_back(8'hAC);
            data_q.push_back(pick_cipher());
        end
        data_q.push_back(akm_field[7:0]);
        data_q.push_back(akm_field[15:8]);
        repeat (n_akm) begin
            data_q.push_back(8'h00);
            data_q.push_back(8'h0F);
            data_q.push_back(8'hAC);
            data_q.push_back(pick_akm());
        end
        if ($urandom_range(0, 1) == 1) begin
            data_q.push_back(8'($urandom_range(0, 255)));
            data_q.push_back(8'($urandom_range(0, 255)));
        end
        len = data_q.size();
        if ($urandom_range(0, 9) == 0) len = $urandom_range(0, len);
        frame_byte(ID_RSN);
        frame_byte(8'(len));
        for (int unsigned i = 0; i < len; i++) frame_byte(data_q[i]);
    endfunction

    function automatic void put_random_element();
        int unsigned r, len;
        logic [7:0]  id;
        r = $urandom_range(0, 99);
        if (r < 15) begin
            id  = ID_CHANNEL;
            len = ($urandom_range(0, 4) != 0) ? 1 : $urandom_range(0, 4);
        end else if (r < 35) begin
            id  = ID_SSID;
            len = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 12);
        end else if (r < 75) begin
            put_rsn_element();
            return;
        end else begin
            id  = 8'($urandom_range(0, 255));
            len = $urandom_range(0, 8);
        end
        frame_byte(id);
        frame_byte(8'(len));
        repeat (len) frame_byte(8'($urandom_range(0, 255)));
    endfunction

    // Directed frames first, then random frames of elements plus some noise
    function automatic void build_stimulus();
        int unsigned n_elem;
        // channel 255, one-byte SSID of 0, empty SSID, empty RSN
        frame_q = '{ID_CHANNEL, 8'd1, 8'd255, ID_SSID, 8'd1, 8'd0,
                    ID_SSID, 8'd0, ID_RSN, 8'd0};
        close_frame(0);
        // SSID cut off by the end of the frame
        frame_q = '{ID_SSID, 8'd4, 8'h41};
        close_frame(0);
        // RSN whose pairwise count runs past the element data
        frame_q = '{ID_RSN, 8'd10, 8'h01, 8'h00, 8'h00, 8'h0F, 8'hAC, SUITE_CCMP,
                    8'hFF, 8'hFF, 8'h00, 8'h0F};
        close_frame(0);
        while (stim_q.size() < RANDOM_BYTES + 25) begin
            if ($urandom_range(0, 19) == 0) begin
                repeat ($urandom_range(1, 6)) frame_byte(8'($urandom_range(0, 255)));
                close_frame(0);
            end else begin
                n_elem = $urandom_range(1, 4);
                repeat (n_elem) put_random_element();
                if ($urandom_range(0, 9) == 0) close_frame($urandom_range(1, frame_q.size()));
                else close_frame(0);
            end
        end
    endfunction

    // Source side: one transaction per stimulus item with random gaps
    task automatic drive_bodies();
        int unsigned gap;
        foreach (stim_q[i]) begin
            gap = pick_gap();
            if (gap != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= stim_q[i].body;
            s_axis_tlast  <= stim_q[i].eof;
            @(posedge i_clk);
            while (!s_axis_tready) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b0;
    endtask

    // Sink side: random stalls on tready
    always @(posedge i_clk) begin
        if (ready_hold != 0) begin
            ready_hold <= ready_hold - 1;
        end else if (m_axis_tready) begin
            stall_len = pick_gap();
            if (stall_len != 0) begin
                m_axis_tready <= 1'b0;
                ready_hold    <= stall_len - 1;
            end
        end else begin
            m_axis_tready <= 1'b1;
            ready_hold    <= $urandom_range(0, 8);
        end
    end

    // Switch between gapped and back-to-back stretches now and then
    always @(posedge i_clk) begin
        if ($urandom_range(0, 299) == 0) quiet <= ~quiet;
    end

    // Monitors: outputs checked before inputs are noted at the same edge
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_event(m_axis_tuser, m_axis_tdata, m_axis_tlast);
        if (i_rst_n && s_axis_tvalid && s_axis_tready)
            sb.note_body_byte(s_axis_tdata, s_axis_tlast);
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d events outstanding",
                     cycle_count, sb.pending());
            $display("[beacon_info_element_parser] ERROR");
            $finish;
        end
    end

    initial begin
        sb           = new();
        n_frames     = 0;
        n_cut_frames = 0;
        build_stimulus();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        drive_bodies();
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Sent %0d body bytes in %0d frames (%0d cut short); checked %0d events.",
                 stim_q.size(), n_frames, n_cut_frames, sb.n_checked);
        $display("Events included %0d RSN verdicts and %0d SSID ends; %0d mismatches.",
                 sb.n_verdicts, sb.n_ssid_ends, sb.errors);
        if (sb.errors == 0) begin
            $display("[beacon_info_element_parser] OK");
        end else begin
            $display("[beacon_info_element_parser] ERROR");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/bie_pkg.sv
rtl/bie_front.sv
rtl/bie_queue.sv
rtl/bie_back.sv
rtl/beacon_info_element_parser.sv
rtl/bie_checker.sv
tb/sv/tb_beacon_info_element_parser.sv
